// ===== rtl/core/lpmt_pkg.sv =====
// Shared constants, types and codes for the linear probe mask table.
`timescale 1ns / 1ps
package lpmt_pkg;

	localparam int CAPACITY  = 1024;
	localparam int KEY_BITS  = 20;
	localparam int SLOT_BITS = $clog2(CAPACITY);
	localparam int OCC_BITS  = SLOT_BITS + 1;
	localparam int HALF_CAP  = CAPACITY / 2;
	localparam int PAY_BITS  = 64;

	localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
	localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// A classified command as it passes from the front end to the back end.
	typedef struct packed {
		logic [1:0]          operation;
		logic [KEY_BITS-1:0] key;
		logic [PAY_BITS-1:0] payload;
		logic [SLOT_BITS-1:0] home;
		logic                zero_key;
	} cmd_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ===== rtl/core/lpmt_in_if.sv =====
// Request channel: valid/ready handshake with operation, key and payload.
`timescale 1ns / 1ps
interface lpmt_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic [lpmt_pkg::KEY_BITS-1:0] key;
	logic [lpmt_pkg::PAY_BITS-1:0] payload_in;

	modport source (output valid, operation, key, payload_in, input ready);
	modport sink (input valid, operation, key, payload_in, output ready);
endinterface

// ===== rtl/core/lpmt_out_if.sv =====
// Response channel: valid/ready handshake with hit, slot, payload and status.
`timescale 1ns / 1ps
interface lpmt_out_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [lpmt_pkg::SLOT_BITS-1:0] slot;
	logic [lpmt_pkg::PAY_BITS-1:0]  payload_out;
	logic [1:0]                     status;

	modport source (output valid, hit, slot, payload_out, status, input ready);
	modport sink (input valid, hit, slot, payload_out, status, output ready);
endinterface

// ===== rtl/core/lpmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== rtl/core/lpmt_front.sv =====
// Front end: accepts request words, hashes the key over two multiply stages, classifies.
`timescale 1ns / 1ps
module lpmt_front (
	input  logic               clk,
	input  logic               arst_n,
	lpmt_in_if.sink            req,
	input  logic               clearing,
	input  logic               q_full,
	output logic               push,
	output lpmt_pkg::cmd_t     push_cmd
);
	logic                                v_s1, v_s2;
	logic [1:0]                          op_s1, op_s2;
	logic [lpmt_pkg::KEY_BITS-1:0]       key_s1, key_s2;
	logic [lpmt_pkg::PAY_BITS-1:0]       pay_s1, pay_s2;
	logic [31:0]                         m_s1, m_s2;
	logic [31:0]                         key_ext, mix_a, mix_b, mix_c;
	logic                                adv1, adv2, take;

	assign adv2      = !v_s2 || !q_full;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1 && !clearing;
	assign take      = req.valid && req.ready;
	assign push      = v_s2 && !q_full;

	assign key_ext = 32'(req.key);
	assign mix_a   = key_ext ^ (key_ext >> 16);
	assign mix_b   = m_s1 ^ (m_s1 >> 15);
	assign mix_c   = m_s2 ^ (m_s2 >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= take;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && take) begin
			op_s1  <= req.operation;
			key_s1 <= req.key;
			pay_s1 <= req.payload_in;
			m_s1   <= mix_a * lpmt_pkg::MIX_MUL_A;
		end
		if (adv2 && v_s1) begin
			op_s2  <= op_s1;
			key_s2 <= key_s1;
			pay_s2 <= pay_s1;
			m_s2   <= mix_b * lpmt_pkg::MIX_MUL_B;
		end
	end

	always_comb begin
		push_cmd.operation = op_s2;
		push_cmd.key       = key_s2;
		push_cmd.payload   = pay_s2;
		push_cmd.home      = mix_c[lpmt_pkg::SLOT_BITS-1:0];
		push_cmd.zero_key  = (key_s2 == '0);
	end
endmodule

// ===== rtl/core/lpmt_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module lpmt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lpmt_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output lpmt_pkg::cmd_t     head,
	output lpmt_pkg::q_stat_t  stat
);
	lpmt_pkg::cmd_t ent_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;

	assign head       = ent_q[rd_q];
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end
endmodule

// ===== rtl/core/lpmt_back.sv =====
// Back end: clearing sweep, probe walk over the key and payload stores, response register.
`timescale 1ns / 1ps
module lpmt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lpmt_pkg::cmd_t     head,
	input  lpmt_pkg::q_stat_t  q_stat,
	output logic               pop,
	output logic               clearing,
	lpmt_out_if.source         rsp
);
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;

	logic [1:0]                     state_q, state_d;
	lpmt_pkg::cmd_t                 cmd_q;
	logic [lpmt_pkg::SLOT_BITS-1:0] addr_q, clr_q, next_addr;
	logic [lpmt_pkg::OCC_BITS-1:0]  occ_q;

	logic                           out_free, load_out, occ_inc;
	logic                           res_hit;
	logic [lpmt_pkg::SLOT_BITS-1:0] res_slot;
	logic [lpmt_pkg::PAY_BITS-1:0]  res_pay;
	logic [1:0]                     res_status;

	logic                           key_we, pay_we, rd_en;
	logic [lpmt_pkg::SLOT_BITS-1:0] key_waddr, rd_addr;
	logic [lpmt_pkg::KEY_BITS-1:0]  key_wdata, key_rdata;
	logic [lpmt_pkg::PAY_BITS-1:0]  pay_rdata;
	logic                           at_limit, is_insert;

	assign out_free  = !rsp.valid || rsp.ready;
	assign clearing  = (state_q == S_CLEAR);
	assign next_addr = addr_q + lpmt_pkg::SLOT_BITS'(1);
	assign at_limit  = (occ_q >= lpmt_pkg::OCC_BITS'(lpmt_pkg::HALF_CAP));
	assign is_insert = (cmd_q.operation == lpmt_pkg::OP_INSERT);

	lpmt_ram #(.WIDTH(lpmt_pkg::KEY_BITS), .DEPTH(lpmt_pkg::CAPACITY)) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (key_waddr),
		.wr_data (key_wdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (key_rdata)
	);

	lpmt_ram #(.WIDTH(lpmt_pkg::PAY_BITS), .DEPTH(lpmt_pkg::CAPACITY)) u_pay_ram (
		.clk     (clk),
		.wr_en   (pay_we),
		.wr_addr (addr_q),
		.wr_data (cmd_q.payload),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (pay_rdata)
	);

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		load_out   = 1'b0;
		occ_inc    = 1'b0;
		res_hit    = 1'b0;
		res_slot   = '0;
		res_pay    = '0;
		res_status = lpmt_pkg::ST_OK;
		key_we     = 1'b0;
		key_waddr  = addr_q;
		key_wdata  = cmd_q.key;
		pay_we     = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = next_addr;
		case (state_q)
			S_CLEAR: begin
				key_we    = 1'b1;
				key_waddr = clr_q;
				key_wdata = '0;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				rd_addr = head.home;
				if (!q_stat.empty) begin
					if (head.zero_key) begin
						// Rejected outright; needs only the response register.
						res_status = lpmt_pkg::ST_ZERO;
						if (out_free) begin
							pop      = 1'b1;
							load_out = 1'b1;
						end
					end else if (head.operation == lpmt_pkg::OP_INSERT && at_limit) begin
						res_status = lpmt_pkg::ST_FULL;
						if (out_free) begin
							pop      = 1'b1;
							load_out = 1'b1;
						end
					end else begin
						pop     = 1'b1;
						rd_en   = 1'b1;
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (key_rdata == '0) begin
					if (is_insert) begin
						res_hit  = 1'b1;
						res_slot = addr_q;
						res_pay  = cmd_q.payload;
					end
					if (out_free) begin
						load_out = 1'b1;
						key_we   = is_insert;
						pay_we   = is_insert;
						occ_inc  = is_insert;
						state_d  = S_IDLE;
					end
				end else if (!is_insert && key_rdata == cmd_q.key) begin
					res_hit  = 1'b1;
					res_slot = addr_q;
					if (cmd_q.operation == lpmt_pkg::OP_UPDATE) begin
						res_pay = cmd_q.payload;
					end else begin
						res_pay = pay_rdata;
					end
					if (out_free) begin
						load_out = 1'b1;
						pay_we   = (cmd_q.operation == lpmt_pkg::OP_UPDATE);
						state_d  = S_IDLE;
					end
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			occ_q     <= '0;
			rsp.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + lpmt_pkg::SLOT_BITS'(1);
			end
			if (occ_inc) begin
				occ_q <= occ_q + lpmt_pkg::OCC_BITS'(1);
			end
			if (load_out) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == S_IDLE) begin
			addr_q <= head.home;
		end else if (rd_en) begin
			addr_q <= next_addr;
		end
		if (load_out) begin
			rsp.hit         <= res_hit;
			rsp.slot        <= res_slot;
			rsp.payload_out <= res_pay;
			rsp.status      <= res_status;
		end
	end
endmodule

// ===== rtl/core/linear_probe_mask_table_core.sv =====
// Top level of the linear probe mask table: front end, command queue and back end.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake    | Word carries
//  --------+-----------+--------------+----------------------------------------
//  req     | in        | valid, ready | operation, key, payload_in
//  rsp     | out       | valid, ready | hit, slot, payload_out, status
//
//  After reset the key store is swept to empty, one slot a cycle, and req.ready
//  stays low while it is swept. A word then passes through the hash pipeline of the
//  front end and waits in a two-entry queue. The back end issues the read at the
//  home slot from its idle state, then checks one probed slot a cycle and reads the
//  next one on a miss, through the single read port of the key store; it takes no
//  new word until the walk ends and the response register is free. Zero keys and
//  inserts refused at the load limit need no read. Either side may stall on its own.
//
module linear_probe_mask_table_core (
	input  logic     clk,
	input  logic     arst_n,
	lpmt_in_if.sink  req,
	lpmt_out_if.source rsp
);
	// Front end and back end exchange classified commands through the queue; the
	// back end holds the front end off while the key store is being cleared.
	logic                clearing;
	logic                push, pop;
	lpmt_pkg::cmd_t      push_cmd, head;
	lpmt_pkg::q_stat_t   q_stat;

	// Hashes each key through two registered multiplies and flags zero keys.
	lpmt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.clearing (clearing),
		.q_full   (q_stat.full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Short queue so that the hash pipeline and the probe walk stall independently.
	lpmt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// Walks the probe sequence, writes the stores and owns the response register.
	lpmt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.clearing (clearing),
		.rsp      (rsp)
	);
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the linear probe mask table core.
`timescale 1ns / 1ps
//
// Requests go in through the req channel and replies come out through the rsp channel.
// A mirror of the table predicts every reply from the words that the block accepts.
// It holds its own key store, payload store and occupancy count. Replies are checked
// in order against the oldest prediction still waiting.
//
// The stimulus starts with a short directed sequence. It covers zero keys on every
// operation, misses on an empty table and a probe walk that wraps from the last slot
// to the first. It also covers a duplicate insert and the spare operation code.
// A random sequence follows. It runs in four phases of sender idling and receiver
// stalling. While the table is below half load, most of its words are inserts. Once
// the load limit is reached, most are finds and updates of live keys, with a steady
// share of inserts that the block must refuse.
//
module testbench;

	// The spare operation code, which the block handles as a find.
	localparam logic [1:0] OP_SPARE = 2'd3;

	// One reply as the response channel carries it.
	typedef struct packed {
		logic                           hit;
		logic [lpmt_pkg::SLOT_BITS-1:0] slot;
		logic [lpmt_pkg::PAY_BITS-1:0]  payload;
		logic [1:0]                     status;
	} reply_t;

	// Mirror of the table: it predicts each reply and holds the replies still owed.
	class probe_table_mirror;
		logic [lpmt_pkg::KEY_BITS-1:0] key_store [lpmt_pkg::CAPACITY];
		logic [lpmt_pkg::PAY_BITS-1:0] payload_store [lpmt_pkg::CAPACITY];
		int unsigned                   occupancy;
		logic [lpmt_pkg::KEY_BITS-1:0] placed_keys [$];
		reply_t                        expected_replies [$];
		int unsigned                   mismatches, words_taken, replies_seen;
		int unsigned                   hits, refused, rejected;

		function new();
			foreach (key_store[i]) begin
				key_store[i] = '0;
				payload_store[i] = '0;
			end
			occupancy = 0;
		endfunction

		// This is the 32-bit xor-shift-multiply finaliser. Its low bits give the home slot.
		function int unsigned home_of(logic [lpmt_pkg::KEY_BITS-1:0] key);
			logic [31:0] v;
			v = 32'(key);
			v = v ^ (v >> 16);
			v = v * lpmt_pkg::MIX_MUL_A;
			v = v ^ (v >> 15);
			v = v * lpmt_pkg::MIX_MUL_B;
			v = v ^ (v >> 16);
			return v & (lpmt_pkg::CAPACITY - 1);
		endfunction

		function reply_t predict_reply(logic [1:0] op, logic [lpmt_pkg::KEY_BITS-1:0] key,
				logic [lpmt_pkg::PAY_BITS-1:0] pay);
			reply_t      r;
			int unsigned s;
			r = '0;
			r.status = lpmt_pkg::ST_OK;
			if (key == '0) begin
				r.status = lpmt_pkg::ST_ZERO;
			end else if (op == lpmt_pkg::OP_INSERT) begin
				if ((occupancy + 1) * 2 > lpmt_pkg::CAPACITY) begin
					r.status = lpmt_pkg::ST_FULL;
				end else begin
					// Below half load an empty slot always lies somewhere on the walk.
					s = home_of(key);
					while (key_store[s] != '0)
						s = (s + 1) % lpmt_pkg::CAPACITY;
					key_store[s] = key;
					payload_store[s] = pay;
					occupancy++;
					placed_keys = {placed_keys, key};
					r.hit = 1'b1;
					r.slot = s[lpmt_pkg::SLOT_BITS-1:0];
					r.payload = pay;
				end
			end else begin
				// Find, update and the spare code all walk to the key or to an empty slot.
				s = home_of(key);
				while (key_store[s] != '0 && key_store[s] != key)
					s = (s + 1) % lpmt_pkg::CAPACITY;
				if (key_store[s] == key) begin
					if (op == lpmt_pkg::OP_UPDATE)
						payload_store[s] = pay;
					r.hit = 1'b1;
					r.slot = s[lpmt_pkg::SLOT_BITS-1:0];
					r.payload = payload_store[s];
				end
			end
			return r;
		endfunction

		function void note_request(logic [1:0] op, logic [lpmt_pkg::KEY_BITS-1:0] key,
				logic [lpmt_pkg::PAY_BITS-1:0] pay);
			reply_t r;
			r = predict_reply(op, key, pay);
			words_taken++;
			if (r.hit)
				hits++;
			if (r.status == lpmt_pkg::ST_FULL)
				refused++;
			if (r.status == lpmt_pkg::ST_ZERO)
				rejected++;
			expected_replies = {expected_replies, r};
		endfunction

		function void check_reply(logic hit, logic [lpmt_pkg::SLOT_BITS-1:0] slot,
				logic [lpmt_pkg::PAY_BITS-1:0] pay, logic [1:0] status);
			reply_t want;
			replies_seen++;
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: reply with none expected: hit %0d slot %0d",
						$time, hit, slot, " payload %h status %0d", pay, status);
				return;
			end
			want = expected_replies.pop_front();
			if (hit !== want.hit || slot !== want.slot || pay !== want.payload ||
					status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: reply %0d mismatch: expected hit %0d slot %0d",
						$time, replies_seen, want.hit, want.slot,
						" payload %h status %0d", want.payload, want.status);
					$display("    got hit %0d slot %0d payload %h status %0d",
						hit, slot, pay, status);
				end
			end
		endfunction
	endclass

	// The phases of idling. The sender idles and the receiver stalls, in percent of cycles.
	localparam int unsigned SRC_IDLE [4]  = '{0, 47, 0, 22};
	localparam int unsigned SINK_STALL [4] = '{0, 0, 47, 22};
	localparam int unsigned WORDS_PER_PHASE = 157;

	logic clk;
	logic arst_n;
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;

	lpmt_in_if  req_if ();
	lpmt_out_if rsp_if ();

	probe_table_mirror table_mirror = new();

	linear_probe_mask_table_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver decides at each falling edge whether it will take a word at the
	// next rising edge.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready = arst_n && ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Replies are sampled at the rising edge, where the handshake completes.
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			table_mirror.check_reply(rsp_if.hit, rsp_if.slot, rsp_if.payload_out,
				rsp_if.status);
	end

	// Entered at a falling edge, and it returns at the falling edge after the word is taken.
	// The valid line is only lowered when the sender decides to idle. A word that follows
	// at once therefore keeps valid high without a glitch.
	task automatic send_word(input logic [1:0] op, input logic [lpmt_pkg::KEY_BITS-1:0] key,
			input logic [lpmt_pkg::PAY_BITS-1:0] pay);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.operation = op;
		req_if.key = key;
		req_if.payload_in = pay;
		do
			@(posedge clk);
		while (!req_if.ready);
		table_mirror.note_request(op, key, pay);
		@(negedge clk);
	endtask

	// This returns the nth nonzero key whose home slot is the given one. The directed
	// part uses it to build a run of keys that collide.
	function automatic logic [lpmt_pkg::KEY_BITS-1:0] key_at_home(int unsigned home,
			int unsigned nth);
		int unsigned k;
		int unsigned seen;
		seen = 0;
		for (k = 1; k < (1 << lpmt_pkg::KEY_BITS); k++) begin
			if (table_mirror.home_of(k[lpmt_pkg::KEY_BITS-1:0]) == home) begin
				if (seen == nth)
					return k[lpmt_pkg::KEY_BITS-1:0];
				seen++;
			end
		end
		return '1;
	endfunction

	task automatic random_word();
		int unsigned                   pick, style, a, b;
		logic [31:0]                   raw;
		logic [1:0]                    op;
		logic [lpmt_pkg::KEY_BITS-1:0] key;
		logic [lpmt_pkg::PAY_BITS-1:0] pay;
		pick = $urandom_range(0, 99);
		// Below half load the table is filled. At the limit, lookups dominate, and the
		// inserts that remain must be refused.
		if (table_mirror.occupancy < lpmt_pkg::HALF_CAP)
			op = pick < 88 ? lpmt_pkg::OP_INSERT : pick < 94 ? lpmt_pkg::OP_FIND :
				pick < 98 ? lpmt_pkg::OP_UPDATE : OP_SPARE;
		else
			op = pick < 20 ? lpmt_pkg::OP_INSERT : pick < 55 ? lpmt_pkg::OP_FIND :
				pick < 92 ? lpmt_pkg::OP_UPDATE : OP_SPARE;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			key = '0;
		end else if (table_mirror.placed_keys.size() != 0 &&
				((op != lpmt_pkg::OP_INSERT && pick < 75) ||
				(op == lpmt_pkg::OP_INSERT && pick < 12))) begin
			// A live key. On an insert this places a duplicate further along the walk.
			key = table_mirror.placed_keys[$urandom_range(0,
				table_mirror.placed_keys.size() - 1)];
		end else begin
			// A fresh mask, which is dense, sparse or the complement of a sparse one.
			style = $urandom_range(0, 2);
			a = $urandom_range(0, lpmt_pkg::KEY_BITS - 1);
			b = $urandom_range(0, lpmt_pkg::KEY_BITS - 1);
			raw = $urandom;
			if (style == 1)
				raw = (32'd1 << a) | (32'd1 << b);
			else if (style == 2)
				raw = ~((32'd1 << a) | (32'd1 << b));
			key = raw[lpmt_pkg::KEY_BITS-1:0];
		end
		style = $urandom_range(0, 9);
		if (style == 0)
			pay = '0;
		else if (style == 1)
			pay = '1;
		else
			pay = {$urandom, $urandom};
		send_word(op, key, pay);
	endtask

	initial begin
		logic [lpmt_pkg::KEY_BITS-1:0] wrap_a, wrap_b, wrap_c, wrap_d;
		int unsigned                   phase;

		req_if.valid = 1'b0;
		req_if.operation = lpmt_pkg::OP_FIND;
		req_if.key = '0;
		req_if.payload_in = '0;
		arst_n = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Four keys share the last slot as home. The second and third must wrap round
		// to slots zero and one.
		wrap_a = key_at_home(lpmt_pkg::CAPACITY - 1, 0);
		wrap_b = key_at_home(lpmt_pkg::CAPACITY - 1, 1);
		wrap_c = key_at_home(lpmt_pkg::CAPACITY - 1, 2);
		wrap_d = key_at_home(lpmt_pkg::CAPACITY - 1, 3);

		// A zero key is rejected whatever the operation.
		send_word(lpmt_pkg::OP_FIND, '0, '1);
		send_word(lpmt_pkg::OP_INSERT, '0, '1);
		send_word(lpmt_pkg::OP_UPDATE, '0, '1);
		send_word(OP_SPARE, '0, '1);
		// Misses on an empty table.
		send_word(lpmt_pkg::OP_FIND, wrap_a, '0);
		send_word(lpmt_pkg::OP_UPDATE, wrap_a, 64'h0123_4567_89ab_cdef);
		// A colliding run that wraps past the end of the table.
		send_word(lpmt_pkg::OP_INSERT, wrap_a, '1);
		send_word(lpmt_pkg::OP_INSERT, wrap_b, '0);
		send_word(lpmt_pkg::OP_INSERT, wrap_c, 64'hdead_beef_0bad_f00d);
		send_word(lpmt_pkg::OP_FIND, wrap_b, '1);
		send_word(lpmt_pkg::OP_FIND, wrap_c, '0);
		send_word(lpmt_pkg::OP_UPDATE, wrap_c, 64'h8000_0000_0000_0001);
		send_word(OP_SPARE, wrap_c, '0);
		// These are the extreme keys.
		send_word(lpmt_pkg::OP_INSERT, '1, 64'ha5a5_a5a5_a5a5_a5a5);
		send_word(lpmt_pkg::OP_INSERT, lpmt_pkg::KEY_BITS'(1), 64'h5a5a_5a5a_5a5a_5a5a);
		// A duplicate goes further along the walk. Lookups still reach the first copy.
		send_word(lpmt_pkg::OP_INSERT, wrap_a, 64'h1111_2222_3333_4444);
		send_word(lpmt_pkg::OP_UPDATE, wrap_a, 64'h7fff_ffff_ffff_fffe);
		send_word(lpmt_pkg::OP_FIND, wrap_a, '0);
		send_word(lpmt_pkg::OP_FIND, '1, '0);
		send_word(OP_SPARE, lpmt_pkg::KEY_BITS'(1), '1);
		// This miss walks the whole colliding run before it meets an empty slot.
		send_word(lpmt_pkg::OP_FIND, wrap_d, '0);
		send_word(lpmt_pkg::OP_UPDATE, wrap_d, '1);

		for (phase = 0; phase < 4; phase++) begin
			src_idle_pct = SRC_IDLE[phase];
			sink_stall_pct = SINK_STALL[phase];
			repeat (WORDS_PER_PHASE) random_word();
		end
		req_if.valid = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;

		while (table_mirror.expected_replies.size() != 0)
			@(posedge clk);
		// Nothing more should come out. Give a stray reply time to show itself.
		repeat (64) @(posedge clk);

		$display("Run covered %0d request words and %0d replies, of which %0d were hits.",
			table_mirror.words_taken, table_mirror.replies_seen, table_mirror.hits);
		$display("Final occupancy was %0d, with %0d inserts refused and %0d zero keys rejected.",
			table_mirror.occupancy, table_mirror.refused, table_mirror.rejected);
		if (table_mirror.mismatches == 0 && table_mirror.expected_replies.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("%0d mismatches, %0d replies outstanding", table_mirror.mismatches,
				table_mirror.expected_replies.size());
			$display("testbench: FAIL");
		end
		$finish;
	end

	// This is a watchdog for a hung handshake. It is generous even when every walk is long.
	initial begin
		#20_000_000;
		$display("Timed out with %0d replies outstanding",
			table_mirror.expected_replies.size());
		$display("testbench: FAIL");
		$finish;
	end

endmodule
